/* rtl/core/cdcalc_pkg.sv */
// Package for the clock divisor calculator: transfer types, codes, constants
// and small helper functions shared by the core, its cells and its checker.
// Depends on nothing.
package cdcalc_pkg;

	localparam int FREQ_W  = 30;
	localparam int SRC_W   = 4;
	localparam int DIV_W   = 24;
	localparam int FRAC_W  = 12;
	localparam int TGT_W   = 32;
	localparam int CTL_W   = 32;
	localparam int NUM_W   = FREQ_W + FRAC_W + 1;
	localparam int DEN_W   = TGT_W;
	localparam int N_CELLS = NUM_W;
	localparam int LATENCY = N_CELLS + 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = FREQ_W;

	localparam logic [1:0] ACT_FREQ_TO_DIV = 2'd0;
	localparam logic [1:0] ACT_CLAMP_DIV   = 2'd1;
	localparam logic [1:0] ACT_DIV_TO_FREQ = 2'd2;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_UNKNOWN_SRC = 2'd1;
	localparam logic [1:0] ST_NOT_RUNNING = 2'd2;
	localparam logic [1:0] ST_ZERO_TARGET = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_OSC_FREQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLL_FREQ = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OSC_SRC  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLL_SRC  = 2'd3;

	localparam logic [FREQ_W-1:0] OSC_FREQ_RST = 30'd19200000;
	localparam logic [FREQ_W-1:0] PLL_FREQ_RST = 30'd500000000;
	localparam logic [SRC_W-1:0]  OSC_SRC_RST  = 4'd1;
	localparam logic [SRC_W-1:0]  PLL_SRC_RST  = 4'd6;

	localparam logic [DIV_W-1:0]  DIV_MAX   = 24'hFFFFFF;
	localparam logic [DIV_W-1:0]  FRAC_OFF  = 24'hFFF000;
	localparam logic [FREQ_W-1:0] FREQ_MAX  = 30'h3FFFFFFF;
	localparam logic [7:0]        CTL_PASSWD = 8'h5A;

	typedef struct packed {
		logic [1:0]       action;
		logic [SRC_W-1:0] source;
		logic [1:0]       mash;
		logic [TGT_W-1:0] target_freq_hz;
		logic [DIV_W-1:0] div_word;
		logic             running;
	} cdcalc_in_t;

	typedef struct packed {
		logic [DIV_W-1:0]  divisor;
		logic [CTL_W-1:0]  ctl_word;
		logic [FREQ_W-1:0] freq_hz;
		logic [1:0]        status;
	} cdcalc_out_t;

	typedef struct packed {
		logic [FREQ_W-1:0] osc_freq_hz;
		logic [FREQ_W-1:0] pll_freq_hz;
		logic [SRC_W-1:0]  osc_source_code;
		logic [SRC_W-1:0]  pll_source_code;
	} cdcalc_cfg_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [1:0]       status;
		logic [1:0]       mash;
		logic [SRC_W-1:0] source;
	} cdcalc_tag_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic [NUM_W-1:0] quo;
		cdcalc_tag_t      tag;
	} cdcalc_stage_t;

	function automatic logic [DIV_W-1:0] min_div(input logic [1:0] mash);
		logic [DIV_W-1:0] m;
		case (mash)
			2'd0: m = 24'h001000;
			2'd1: m = 24'h002000;
			2'd2: m = 24'h003000;
			default: m = 24'h005000;
		endcase
		return m;
	endfunction

	function automatic logic [CTL_W-1:0] make_ctl(input logic [SRC_W-1:0] src,
		input logic [1:0] mash);
		logic [CTL_W-1:0] c;
		c = '0;
		c[31:24] = CTL_PASSWD;
		c[10:9] = mash;
		c[4] = 1'b1;
		c[3:0] = src;
		return c;
	endfunction

endpackage

/* rtl/core/cdcalc_prep.sv */
// Entry stage of the clock divisor calculator: source lookup, error checks
// and set-up of numerator and denominator for the divider cell chain.
// Depends on cdcalc_pkg.
module cdcalc_prep (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  cdcalc_pkg::cdcalc_in_t  item,
	input  cdcalc_pkg::cdcalc_cfg_t cfg,
	output logic                    valid_s1,
	output cdcalc_pkg::cdcalc_stage_t stage_s1
);

	logic [cdcalc_pkg::FREQ_W-1:0] sf;
	logic                          src_bad;
	logic [cdcalc_pkg::DIV_W-1:0]  mash_min;
	logic [cdcalc_pkg::DIV_W-1:0]  d_masked;
	logic [cdcalc_pkg::DIV_W-1:0]  d_clamped;
	logic [cdcalc_pkg::NUM_W-1:0]  scaled;
	cdcalc_pkg::cdcalc_stage_t     nxt;

	always_comb begin
		if (item.source == cfg.osc_source_code) begin
			sf = cfg.osc_freq_hz;
		end else if (item.source == cfg.pll_source_code) begin
			sf = cfg.pll_freq_hz;
		end else begin
			sf = '0;
		end
		src_bad = (sf == '0);
		mash_min = cdcalc_pkg::min_div(item.mash);
		d_masked = (item.mash == 2'd0) ? (item.div_word & cdcalc_pkg::FRAC_OFF)
			: item.div_word;
		d_clamped = (d_masked < mash_min) ? mash_min : d_masked;
		scaled = {1'b0, sf, {cdcalc_pkg::FRAC_W{1'b0}}};

		nxt.rem = '0;
		nxt.quo = '0;
		nxt.tag.action = item.action;
		nxt.tag.mash = item.mash;
		nxt.tag.source = item.source;
		nxt.tag.status = cdcalc_pkg::ST_OK;
		nxt.num = '0;
		nxt.den = cdcalc_pkg::DEN_W'(1);
		case (item.action)
			cdcalc_pkg::ACT_FREQ_TO_DIV: begin
				nxt.den = item.target_freq_hz;
				nxt.num = scaled + cdcalc_pkg::NUM_W'(item.target_freq_hz >> 1);
				if (src_bad) begin
					nxt.tag.status = cdcalc_pkg::ST_UNKNOWN_SRC;
				end else if (item.target_freq_hz == '0) begin
					nxt.tag.status = cdcalc_pkg::ST_ZERO_TARGET;
				end
			end
			cdcalc_pkg::ACT_CLAMP_DIV: begin
				nxt.num = cdcalc_pkg::NUM_W'(item.div_word);
			end
			cdcalc_pkg::ACT_DIV_TO_FREQ: begin
				nxt.den = cdcalc_pkg::DEN_W'(d_clamped);
				nxt.num = scaled + cdcalc_pkg::NUM_W'(d_clamped >> 1);
				if (!item.running) begin
					nxt.tag.status = cdcalc_pkg::ST_NOT_RUNNING;
				end else if (src_bad) begin
					nxt.tag.status = cdcalc_pkg::ST_UNKNOWN_SRC;
				end
			end
			default: begin
				nxt.num = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		stage_s1 <= nxt;
	end

endmodule

/* rtl/core/cdcalc_cell.sv */
// One cell of the divider chain: a restoring step that yields one quotient
// bit and hands remainder, operands and tag to the next cell.
// Depends on cdcalc_pkg.
module cdcalc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_in,
	input  cdcalc_pkg::cdcalc_stage_t stage_in,
	output logic                      valid_s1,
	output cdcalc_pkg::cdcalc_stage_t stage_s1
);

	logic [cdcalc_pkg::DEN_W:0] part;
	logic [cdcalc_pkg::DEN_W:0] diff;
	logic                       take;
	cdcalc_pkg::cdcalc_stage_t  nxt;

	always_comb begin
		part = {stage_in.rem, stage_in.num[cdcalc_pkg::NUM_W-1]};
		diff = part - {1'b0, stage_in.den};
		take = (part >= {1'b0, stage_in.den});
		nxt = stage_in;
		nxt.rem = take ? diff[cdcalc_pkg::DEN_W-1:0] : part[cdcalc_pkg::DEN_W-1:0];
		nxt.num = {stage_in.num[cdcalc_pkg::NUM_W-2:0], 1'b0};
		nxt.quo = {stage_in.quo[cdcalc_pkg::NUM_W-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		stage_s1 <= nxt;
	end

endmodule

/* rtl/core/cdcalc_post.sv */
// Output stage of the clock divisor calculator: saturation and clamping of
// the quotient, control word assembly and the result register.
// Depends on cdcalc_pkg.
module cdcalc_post (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_in,
	input  cdcalc_pkg::cdcalc_stage_t stage_in,
	output logic                      done,
	output cdcalc_pkg::cdcalc_out_t   result
);

	logic [cdcalc_pkg::DIV_W-1:0] mash_min;
	logic [cdcalc_pkg::DIV_W-1:0] div_sat;
	cdcalc_pkg::cdcalc_out_t      nxt;
	logic                         done_s1;
	cdcalc_pkg::cdcalc_out_t      result_s1;

	always_comb begin
		mash_min = cdcalc_pkg::min_div(stage_in.tag.mash);
		div_sat = (|stage_in.quo[cdcalc_pkg::NUM_W-1:cdcalc_pkg::DIV_W])
			? cdcalc_pkg::DIV_MAX : stage_in.quo[cdcalc_pkg::DIV_W-1:0];
		nxt = '0;
		nxt.status = stage_in.tag.status;
		if (stage_in.tag.status == cdcalc_pkg::ST_OK) begin
			case (stage_in.tag.action)
				cdcalc_pkg::ACT_FREQ_TO_DIV, cdcalc_pkg::ACT_CLAMP_DIV: begin
					nxt.divisor = (div_sat < mash_min) ? mash_min : div_sat;
					nxt.ctl_word = cdcalc_pkg::make_ctl(stage_in.tag.source,
						stage_in.tag.mash);
				end
				cdcalc_pkg::ACT_DIV_TO_FREQ: begin
					nxt.freq_hz = (|stage_in.quo[cdcalc_pkg::NUM_W-1:cdcalc_pkg::FREQ_W])
						? cdcalc_pkg::FREQ_MAX : stage_in.quo[cdcalc_pkg::FREQ_W-1:0];
				end
				default: begin
					nxt = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		result_s1 <= nxt;
	end

	assign done = done_s1;
	assign result = result_s1;

endmodule

/* rtl/core/clock_divisor_calculator_core.sv */
// Top level of the clock divisor calculator: configuration registers, entry
// stage, divider cell chain and output stage.
// Depends on cdcalc_pkg, cdcalc_prep, cdcalc_cell and cdcalc_post.
//
// Usage: an item is transferred at a rising edge with start high and busy
// low. Busy is never raised, so an item may be given in every cycle.
// Each item gives one result, shown on result with done high for exactly
// one cycle; the receiver cannot hold it off and must take it then.
// An item passes one entry register, the divider chain of 43 cells, one
// quotient bit per cell, and one output register. Throughput is one item
// per cycle. Actions: 0 gives a divisor word from a target frequency, 1
// clamps a given divisor word, 2 gives a frequency from a read-back divisor
// word. Configuration is written through cfg_we, cfg_index and cfg_wdata;
// the user must do so only while no item is in flight, which the block does
// not enforce. Reset restores the default frequencies and source codes and
// empties the pipeline; items in flight are lost.
module clock_divisor_calculator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cdcalc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cdcalc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                                 start,
	input  cdcalc_pkg::cdcalc_in_t               item,
	output logic                                 busy,
	output logic                                 done,
	output cdcalc_pkg::cdcalc_out_t              result
);

	cdcalc_pkg::cdcalc_cfg_t   cfg_q;
	logic                      chain_valid [0:cdcalc_pkg::N_CELLS];
	cdcalc_pkg::cdcalc_stage_t chain_stage [0:cdcalc_pkg::N_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.osc_freq_hz <= cdcalc_pkg::OSC_FREQ_RST;
			cfg_q.pll_freq_hz <= cdcalc_pkg::PLL_FREQ_RST;
			cfg_q.osc_source_code <= cdcalc_pkg::OSC_SRC_RST;
			cfg_q.pll_source_code <= cdcalc_pkg::PLL_SRC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cdcalc_pkg::REG_OSC_FREQ: cfg_q.osc_freq_hz <= cfg_wdata;
				cdcalc_pkg::REG_PLL_FREQ: cfg_q.pll_freq_hz <= cfg_wdata;
				cdcalc_pkg::REG_OSC_SRC: cfg_q.osc_source_code <= cfg_wdata[cdcalc_pkg::SRC_W-1:0];
				cdcalc_pkg::REG_PLL_SRC: cfg_q.pll_source_code <= cfg_wdata[cdcalc_pkg::SRC_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign busy = 1'b0;

	cdcalc_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (start && !busy),
		.item     (item),
		.cfg      (cfg_q),
		.valid_s1 (chain_valid[0]),
		.stage_s1 (chain_stage[0])
	);

	for (genvar i = 0; i < cdcalc_pkg::N_CELLS; i++) begin : g_cell
		cdcalc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (chain_valid[i]),
			.stage_in (chain_stage[i]),
			.valid_s1 (chain_valid[i+1]),
			.stage_s1 (chain_stage[i+1])
		);
	end

	cdcalc_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (chain_valid[cdcalc_pkg::N_CELLS]),
		.stage_in (chain_stage[cdcalc_pkg::N_CELLS]),
		.done     (done),
		.result   (result)
	);

endmodule

/* rtl/core/cdcalc_checker.sv */
// Port-level checker for the clock divisor calculator core, attached by the
// bind statement at the end of this file.
// Depends on cdcalc_pkg and clock_divisor_calculator_core.
module cdcalc_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input cdcalc_pkg::cdcalc_out_t result
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised although the core takes an item in every cycle");

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(cdcalc_pkg::LATENCY) done)
		else $error("accepted item gave no result at the expected cycle");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, cdcalc_pkg::LATENCY))
		else $error("result transfer without a matching accepted item");

	a_error_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != cdcalc_pkg::ST_OK)) |->
		((result.divisor == '0) && (result.ctl_word == '0) && (result.freq_hz == '0)))
		else $error("error result carries non-zero fields");

	a_ctl_format: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.ctl_word != '0)) |->
		((result.ctl_word[31:24] == cdcalc_pkg::CTL_PASSWD) && result.ctl_word[4]
		&& (result.freq_hz == '0)))
		else $error("control word malformed or given with a frequency");

endmodule

bind clock_divisor_calculator_core cdcalc_checker u_cdcalc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
